>>> hw/rtl/jpeg_quality_quantizer_core_macros.svh
// Assertion macros used by the quantizer checker.
`ifndef JPEG_QUALITY_QUANTIZER_CORE_MACROS_SVH
`define JPEG_QUALITY_QUANTIZER_CORE_MACROS_SVH

// Check cons in the same cycle as ante.
`define JQQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// Check cons in the cycle after ante.
`define JQQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

>>> hw/rtl/jqq_pkg.sv
// Package: types and constants of the quality-scaled quantizer.
`default_nettype none
package jqq_pkg;

    localparam int COEF_W     = 16;
    localparam int BASE_W     = 8;
    localparam int STEP_W     = 8;
    localparam int RECIP_W    = 15;
    localparam int QUALITY_W  = 7;
    localparam int INDEX_W    = 6;
    localparam int ADDR_W     = INDEX_W + 1;
    localparam int TABLE_DEPTH = 1 << ADDR_W;
    localparam int NUM_W      = 21;
    localparam int DEN_W      = 13;
    localparam int SCALE_W    = 13;
    localparam int CNT_W      = 4;
    localparam int RECIP_NUM_W = RECIP_W + 2;
    localparam int BASE_FRAC_BITS = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W     = 2;

    localparam int QUALITY_RESET = 50;
    localparam int QUALITY_MIN   = 1;
    localparam int QUALITY_MAX   = 100;
    localparam int Q_KNEE        = 50;
    localparam int S_NUM         = 5000;
    localparam int S_BASE        = 200;
    localparam int ROUND_BIAS    = 50;
    localparam int PCT_SCALE     = 100;
    localparam int STEP_MAX      = 255;
    localparam int RECIP_MAX     = 'h7FFF;
    localparam int RECIP_ONE     = 1 << (RECIP_W + 1);

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUANT = 1'b1;

    typedef logic [QUALITY_W-1:0] t_quality;

    typedef struct packed {
        logic                       action;
        logic                       table_select;
        logic [INDEX_W-1:0]         index;
        logic [BASE_W-1:0]          base_step;
        logic signed [COEF_W-1:0]   coefficient;
    } t_in_item;

    typedef struct packed {
        logic signed [COEF_W-1:0]   value;
        logic [STEP_W-1:0]          step_size;
    } t_out_item;

    typedef struct packed {
        logic                       action;
        logic [ADDR_W-1:0]          addr;
        logic signed [COEF_W-1:0]   coef;
        logic [NUM_W-1:0]           num;
        logic [DEN_W-1:0]           den;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_q_head;

    typedef enum logic [2:0] {
        DIV_IDLE,
        DIV_SCALE,
        DIV_STEP,
        DIV_RECIP,
        DIV_WRITE,
        DIV_DONE
    } t_div_state;

endpackage
`default_nettype wire

>>> hw/rtl/jqq_stream_if.sv
// Interface: valid/ready channel carrying one payload.
`default_nettype none
interface jqq_stream_if #(
    parameter type t_data = logic
) ();
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/jpeg_quality_quantizer_core.sv
// Top level of the JPEG quality-scaled quantizer.
//
// Channels: i_in takes items (load a table entry or quantize a coefficient),
// o_out returns one result per item in order, i_cfg writes the quality
// register (always ready, write only while the block is idle).
// Quantize: job queue, then r_s1 (table read), r_s2 (product) and the output register;
// one item per cycle sustained while no load divides and the output is taken, set by
// the single multiply stage and the table read port.
// Load: the shared restoring divider forms the scaled step (8 iterations), then the
// reciprocal (15 iterations, skipped when the step clamps to 1), then the table is
// written; the back end takes the next item only after the load result moves on.
// A 4-entry job queue lets inputs keep arriving while a load divides;
// i_in.ready drops when that queue is full.
// Reset: queue and pipeline empty, quality 50; table entries hold no
// defined value until loaded.
// Receiver stall: the output register holds its result, the pipeline
// stalls back to the queue, then the queue fills and input ready drops.
`default_nettype none
module jpeg_quality_quantizer_core #(
    parameter int FRAC_BITS = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    jqq_stream_if.sink   i_in,
    jqq_stream_if.sink   i_cfg,
    jqq_stream_if.source o_out
);
    jqq_pkg::t_q_head w_push;
    jqq_pkg::t_q_head w_head;
    logic             w_q_ready;
    logic             w_pop;

    jqq_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_cfg     (i_cfg),
        .i_q_ready (w_q_ready),
        .o_push    (w_push)
    );

    jqq_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_ready (w_q_ready),
        .o_head  (w_head),
        .i_pop   (w_pop)
    );

    jqq_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );
endmodule
`default_nettype wire

>>> hw/rtl/jqq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module jqq_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule
`default_nettype wire

>>> hw/rtl/jqq_front.sv
// Front end: quality register, input acceptance and scaling setup per item.
`default_nettype none
module jqq_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    jqq_stream_if.sink       i_in,
    jqq_stream_if.sink       i_cfg,
    input  logic             i_q_ready,
    output jqq_pkg::t_q_head o_push
);
    jqq_pkg::t_quality               r_quality;
    jqq_pkg::t_quality               w_q;
    logic                            w_low;
    logic [jqq_pkg::SCALE_W-1:0]     w_fac;
    logic [jqq_pkg::SCALE_W-1:0]     w_bias;
    jqq_pkg::t_in_item               w_item;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = i_q_ready;
    assign w_item      = i_in.data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quality <= jqq_pkg::QUALITY_W'(jqq_pkg::QUALITY_RESET);
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_quality <= i_cfg.data;
        end
    end

    always_comb begin
        if (r_quality < jqq_pkg::QUALITY_W'(jqq_pkg::QUALITY_MIN)) begin
            w_q = jqq_pkg::QUALITY_W'(jqq_pkg::QUALITY_MIN);
        end else if (r_quality > jqq_pkg::QUALITY_W'(jqq_pkg::QUALITY_MAX)) begin
            w_q = jqq_pkg::QUALITY_W'(jqq_pkg::QUALITY_MAX);
        end else begin
            w_q = r_quality;
        end
    end

    assign w_low = (w_q < jqq_pkg::QUALITY_W'(jqq_pkg::Q_KNEE));

    always_comb begin
        if (w_low) begin
            w_fac  = jqq_pkg::SCALE_W'(jqq_pkg::S_NUM);
            w_bias = jqq_pkg::SCALE_W'(w_q) * jqq_pkg::SCALE_W'(jqq_pkg::ROUND_BIAS);
        end else begin
            w_fac  = jqq_pkg::SCALE_W'(jqq_pkg::S_BASE) - jqq_pkg::SCALE_W'({w_q, 1'b0});
            w_bias = jqq_pkg::SCALE_W'(jqq_pkg::ROUND_BIAS);
        end
    end

    always_comb begin
        o_push.valid      = i_in.valid && i_in.ready;
        o_push.job.action = w_item.action;
        o_push.job.addr   = {w_item.table_select, w_item.index};
        o_push.job.coef   = w_item.coefficient;
        o_push.job.num    = jqq_pkg::NUM_W'(w_item.base_step) * jqq_pkg::NUM_W'(w_fac)
                          + jqq_pkg::NUM_W'(w_bias);
        o_push.job.den    = w_low
                          ? jqq_pkg::DEN_W'(w_q) * jqq_pkg::DEN_W'(jqq_pkg::PCT_SCALE)
                          : jqq_pkg::DEN_W'(jqq_pkg::PCT_SCALE);
    end
endmodule
`default_nettype wire

>>> hw/rtl/jqq_queue.sv
// Job queue between front end and back end.
`default_nettype none
module jqq_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  jqq_pkg::t_q_head i_push,
    output logic             o_ready,
    output jqq_pkg::t_q_head o_head,
    input  logic             i_pop
);
    jqq_pkg::t_job               r_slot [jqq_pkg::QUEUE_DEPTH];
    logic [jqq_pkg::QPTR_W-1:0]  r_wr_ptr;
    logic [jqq_pkg::QPTR_W-1:0]  r_rd_ptr;
    logic [jqq_pkg::QPTR_W:0]    r_count;
    logic                        w_pop;

    assign o_ready     = (r_count != (jqq_pkg::QPTR_W + 1)'(jqq_pkg::QUEUE_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.job  = r_slot[r_rd_ptr];
    assign w_pop       = i_pop && o_head.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push.valid && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push.valid && w_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_slot[r_wr_ptr] <= i_push.job;
        end
    end
endmodule
`default_nettype wire

>>> hw/rtl/jqq_back.sv
// Back end: table store, step and reciprocal divider, quantize pipeline, output register.
`default_nettype none
module jqq_back #(
    parameter int FRAC_BITS = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  jqq_pkg::t_q_head i_head,
    output logic             o_pop,
    jqq_stream_if.source     o_out
);
    localparam int PROD_W = jqq_pkg::COEF_W + jqq_pkg::RECIP_W + 1;
    localparam int SUM_W  = PROD_W + 1;
    localparam int SHIFT  = jqq_pkg::RECIP_W + FRAC_BITS - jqq_pkg::BASE_FRAC_BITS;
    localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) << (SHIFT - 1);
    localparam int REM_W  = jqq_pkg::DEN_W;
    localparam int PAD_W  = jqq_pkg::NUM_W - jqq_pkg::RECIP_W;

    // pipeline control
    logic                        r_s1_vld;
    jqq_pkg::t_job               r_s1;
    logic                        r_s2_vld;
    logic                        r_s2_load;
    logic signed [PROD_W-1:0]    r_s2_prod;
    logic [jqq_pkg::STEP_W-1:0]  r_s2_step;
    logic                        r_o_vld;
    jqq_pkg::t_out_item          r_o;
    logic                        w_s1_go;
    logic                        w_s1_ready;
    logic                        w_s2_ready;
    logic                        w_s3_ready;

    // divider
    jqq_pkg::t_div_state         r_state;
    jqq_pkg::t_div_state         n_state;
    logic [REM_W-1:0]            r_rem;
    logic [REM_W-1:0]            n_rem;
    logic [jqq_pkg::NUM_W-1:0]   r_num;
    logic [jqq_pkg::NUM_W-1:0]   n_num;
    logic [jqq_pkg::DEN_W-1:0]   r_den;
    logic [jqq_pkg::DEN_W-1:0]   n_den;
    logic [jqq_pkg::RECIP_W-1:0] r_quo;
    logic [jqq_pkg::RECIP_W-1:0] n_quo;
    logic [jqq_pkg::CNT_W-1:0]   r_cnt;
    logic [jqq_pkg::CNT_W-1:0]   n_cnt;
    logic                        r_sat;
    logic                        n_sat;
    logic [jqq_pkg::STEP_W-1:0]  r_step;
    logic [jqq_pkg::STEP_W-1:0]  n_step;
    logic [REM_W:0]              w_trial;
    logic [REM_W:0]              w_diff;
    logic                        w_ge;
    logic [jqq_pkg::STEP_W-1:0]  w_step;
    logic [jqq_pkg::RECIP_NUM_W-1:0] w_rnum;
    logic                        w_wr_en;

    // datapath
    logic [jqq_pkg::RECIP_W-1:0] w_rd_data;
    logic signed [PROD_W-1:0]    w_prod;
    logic signed [SUM_W-1:0]     w_sum;
    logic signed [SUM_W-1:0]     w_shifted;

    assign w_s3_ready = !r_o_vld || o_out.ready;
    assign w_s2_ready = !r_s2_vld || w_s3_ready;
    assign w_s1_go    = r_s1_vld && w_s2_ready
                     && ((r_s1.action == jqq_pkg::ACT_QUANT) || (r_state == jqq_pkg::DIV_DONE));
    assign w_s1_ready = !r_s1_vld || w_s1_go;
    assign o_pop      = i_head.valid && w_s1_ready;

    jqq_ram #(
        .WIDTH (jqq_pkg::RECIP_W),
        .DEPTH (jqq_pkg::TABLE_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_s1.addr),
        .i_wr_data (r_quo),
        .i_rd_en   (o_pop),
        .i_rd_addr (i_head.job.addr),
        .o_rd_data (w_rd_data)
    );

    assign w_trial = {r_rem, r_num[jqq_pkg::NUM_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_step  = r_sat ? jqq_pkg::STEP_W'(jqq_pkg::STEP_MAX)
                   : ((r_quo[jqq_pkg::STEP_W-1:0] == '0) ? jqq_pkg::STEP_W'(1)
                                                         : r_quo[jqq_pkg::STEP_W-1:0]);
    assign w_rnum  = jqq_pkg::RECIP_NUM_W'(jqq_pkg::RECIP_ONE)
                   + jqq_pkg::RECIP_NUM_W'(w_step);

    always_comb begin
        n_state = r_state;
        case (r_state)
            jqq_pkg::DIV_IDLE: begin
                if (r_s1_vld && (r_s1.action == jqq_pkg::ACT_LOAD)) begin
                    n_state = jqq_pkg::DIV_SCALE;
                end
            end
            jqq_pkg::DIV_SCALE: begin
                if (r_cnt == jqq_pkg::CNT_W'(1)) begin
                    n_state = jqq_pkg::DIV_STEP;
                end
            end
            jqq_pkg::DIV_STEP: begin
                n_state = (w_step == jqq_pkg::STEP_W'(1)) ? jqq_pkg::DIV_WRITE
                                                          : jqq_pkg::DIV_RECIP;
            end
            jqq_pkg::DIV_RECIP: begin
                if (r_cnt == jqq_pkg::CNT_W'(1)) begin
                    n_state = jqq_pkg::DIV_WRITE;
                end
            end
            jqq_pkg::DIV_WRITE: begin
                n_state = jqq_pkg::DIV_DONE;
            end
            jqq_pkg::DIV_DONE: begin
                if (w_s1_go) begin
                    n_state = jqq_pkg::DIV_IDLE;
                end
            end
            default: begin
                n_state = jqq_pkg::DIV_IDLE;
            end
        endcase
    end

    always_comb begin
        n_rem   = r_rem;
        n_num   = r_num;
        n_den   = r_den;
        n_quo   = r_quo;
        n_cnt   = r_cnt;
        n_sat   = r_sat;
        n_step  = r_step;
        w_wr_en = 1'b0;
        case (r_state)
            jqq_pkg::DIV_IDLE: begin
                // quotient below 256 unless saturated: start with the upper bits
                n_rem = r_s1.num[jqq_pkg::NUM_W-1:jqq_pkg::STEP_W];
                n_num = {r_s1.num[jqq_pkg::STEP_W-1:0], REM_W'(0)};
                n_den = r_s1.den;
                n_quo = '0;
                n_cnt = jqq_pkg::CNT_W'(jqq_pkg::STEP_W);
                n_sat = (r_s1.num >= {r_s1.den, jqq_pkg::STEP_W'(0)});
            end
            jqq_pkg::DIV_SCALE, jqq_pkg::DIV_RECIP: begin
                n_rem = w_ge ? w_diff[REM_W-1:0] : w_trial[REM_W-1:0];
                n_num = {r_num[jqq_pkg::NUM_W-2:0], 1'b0};
                n_quo = {r_quo[jqq_pkg::RECIP_W-2:0], w_ge};
                n_cnt = r_cnt - 1'b1;
            end
            jqq_pkg::DIV_STEP: begin
                n_step = w_step;
                n_quo  = (w_step == jqq_pkg::STEP_W'(1)) ? jqq_pkg::RECIP_W'(jqq_pkg::RECIP_MAX)
                                                         : '0;
                n_rem  = REM_W'(w_rnum[jqq_pkg::RECIP_NUM_W-1:jqq_pkg::RECIP_W]);
                n_num  = {w_rnum[jqq_pkg::RECIP_W-1:0], PAD_W'(0)};
                n_den  = jqq_pkg::DEN_W'({w_step, 1'b0});
                n_cnt  = jqq_pkg::CNT_W'(jqq_pkg::RECIP_W);
            end
            jqq_pkg::DIV_WRITE: begin
                w_wr_en = 1'b1;
            end
            jqq_pkg::DIV_DONE: begin
                w_wr_en = 1'b0;
            end
            default: begin
                w_wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= jqq_pkg::DIV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_num  <= n_num;
        r_den  <= n_den;
        r_quo  <= n_quo;
        r_cnt  <= n_cnt;
        r_sat  <= n_sat;
        r_step <= n_step;
    end

    assign w_prod    = $signed(r_s1.coef) * $signed({1'b0, w_rd_data});
    assign w_sum     = $signed({r_s2_prod[PROD_W-1], r_s2_prod}) + HALF;
    assign w_shifted = w_sum >>> SHIFT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else begin
            if (w_s1_ready) begin
                r_s1_vld <= i_head.valid;
            end
            if (w_s2_ready) begin
                r_s2_vld <= w_s1_go;
            end
            if (w_s3_ready) begin
                r_o_vld <= r_s2_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1 <= i_head.job;
        end
        if (w_s1_go) begin
            r_s2_load <= (r_s1.action == jqq_pkg::ACT_LOAD);
            r_s2_prod <= (r_s1.action == jqq_pkg::ACT_LOAD)
                       ? $signed(PROD_W'(r_quo)) : w_prod;
            r_s2_step <= r_step;
        end
        if (w_s3_ready && r_s2_vld) begin
            r_o.value     <= r_s2_load ? r_s2_prod[jqq_pkg::COEF_W-1:0]
                                       : w_shifted[jqq_pkg::COEF_W-1:0];
            r_o.step_size <= r_s2_load ? r_s2_step : '0;
        end
    end

    assign o_out.valid = r_o_vld;
    assign o_out.data  = r_o;
endmodule
`default_nettype wire

>>> hw/rtl/jqq_checker.sv
// Checker: port-level assertions on the quantizer result channel, with its bind.
`default_nettype none
`include "jpeg_quality_quantizer_core_macros.svh"
module jqq_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_out_valid,
    input logic                               i_out_ready,
    input logic signed [jqq_pkg::COEF_W-1:0]  i_out_value,
    input logic [jqq_pkg::STEP_W-1:0]         i_out_step
);
    `JQQ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    `JQQ_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_out_value) && $stable(i_out_step))
    `JQQ_ASSERT_NOW(a_load_recip_pos, i_clk, i_rst_n, i_out_valid && (i_out_step != '0), (i_out_value != '0) && !i_out_value[jqq_pkg::COEF_W-1])
    `JQQ_ASSERT_NOW(a_unit_step_sat, i_clk, i_rst_n, i_out_valid && (i_out_step == jqq_pkg::STEP_W'(1)), i_out_value == jqq_pkg::COEF_W'(jqq_pkg::RECIP_MAX))
endmodule

bind jpeg_quality_quantizer_core jqq_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_value (o_out.data.value),
    .i_out_step  (o_out.data.step_size)
);
`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// Testbench for the quality-scaled quantizer: table loads and quantizations checked against an in-bench model.
module tb;

    localparam int FRAC           = 8;
    localparam int QSHIFT         = jqq_pkg::RECIP_W + FRAC - jqq_pkg::BASE_FRAC_BITS;
    localparam int HUNDRED        = 100;
    localparam int PHASE_ITEMS    = 60;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef jqq_pkg::t_in_item  t_in_item;
    typedef jqq_pkg::t_out_item t_out_item;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    jqq_stream_if #(.t_data(t_in_item))          in_if ();
    jqq_stream_if #(.t_data(jqq_pkg::t_quality)) cfg_if ();
    jqq_stream_if #(.t_data(t_out_item))         out_if ();

    jpeg_quality_quantizer_core #(.FRAC_BITS(FRAC)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    always #2 i_clk = ~i_clk;

    t_in_item    send_queue[$];
    t_out_item   expected_results[$];
    logic [14:0] recip_table [128];
    logic [6:0]  quality_reg = 7'(jqq_pkg::QUALITY_RESET);
    bit          loaded_map [128];
    logic [6:0]  loaded_addrs[$];
    int          n_planned = 0;
    int          n_checked = 0;
    int          n_errors = 0;
    int          src_gap = 0;
    int          snk_gap = 0;
    int          hold_left = 0;
    int          quiet_cycles = 0;
    bit          calm = 1'b0;
    bit          in_taken = 1'b0;
    bit          long_hold_done = 1'b0;

    function automatic logic [7:0] scaled_step(input logic [7:0] base, input logic [6:0] qreg);
        int unsigned q;
        int unsigned b;
        int unsigned s;
        q = qreg;
        b = base;
        if (q < jqq_pkg::QUALITY_MIN) q = jqq_pkg::QUALITY_MIN;
        if (q > jqq_pkg::QUALITY_MAX) q = jqq_pkg::QUALITY_MAX;
        if (q < jqq_pkg::Q_KNEE) begin
            s = (b * jqq_pkg::S_NUM + jqq_pkg::ROUND_BIAS * q) / (HUNDRED * q);
        end else begin
            s = (b * (jqq_pkg::S_BASE - 2 * q) + jqq_pkg::ROUND_BIAS) / HUNDRED;
        end
        if (s < 1) s = 1;
        if (s > jqq_pkg::STEP_MAX) s = jqq_pkg::STEP_MAX;
        return s[7:0];
    endfunction

    task automatic quantizer_model(input t_in_item it);
        t_out_item   res;
        logic [6:0]  addr;
        logic [7:0]  step;
        int unsigned recip;
        longint      prod;
        addr = {it.table_select, it.index};
        res  = '0;
        if (it.action == jqq_pkg::ACT_LOAD) begin
            step  = scaled_step(it.base_step, quality_reg);
            recip = (jqq_pkg::RECIP_ONE + step) / (2 * step);
            if (recip > jqq_pkg::RECIP_MAX) recip = jqq_pkg::RECIP_MAX;
            recip_table[addr] = recip[14:0];
            res.value         = recip[15:0];
            res.step_size     = step;
        end else begin
            prod = longint'(signed'(it.coefficient)) * longint'({1'b0, recip_table[addr]})
                 + (longint'(1) << (QSHIFT - 1));
            prod = prod >>> QSHIFT;
            res.value = prod[15:0];
        end
        expected_results.push_back(res);
    endtask

    task automatic plan_load(input logic sel, input logic [5:0] idx, input logic [7:0] base);
        t_in_item it;
        it.action       = jqq_pkg::ACT_LOAD;
        it.table_select = sel;
        it.index        = idx;
        it.base_step    = base;
        it.coefficient  = 16'($urandom);
        if (!loaded_map[{sel, idx}]) begin
            loaded_map[{sel, idx}] = 1'b1;
            loaded_addrs.push_back({sel, idx});
        end
        send_queue.push_back(it);
        n_planned++;
    endtask

    task automatic plan_quant(input logic [6:0] addr, input logic [15:0] coef);
        t_in_item it;
        it.action                    = jqq_pkg::ACT_QUANT;
        {it.table_select, it.index}  = addr;
        it.base_step                 = 8'($urandom);
        it.coefficient               = coef;
        send_queue.push_back(it);
        n_planned++;
    endtask

    task automatic plan_random(input int n);
        logic [7:0]  base;
        logic [15:0] coef;
        repeat (n) begin
            if (loaded_addrs.size() == 0 || $urandom_range(0, 99) < 20) begin
                case ($urandom_range(0, 7))
                    0: begin
                        base = 8'd0;
                    end
                    1: begin
                        base = 8'hFF;
                    end
                    2, 3: begin
                        base = 8'($urandom);
                    end
                    default: begin
                        base = 8'($urandom_range(1, 120));
                    end
                endcase
                plan_load(1'($urandom), 6'($urandom), base);
            end else begin
                case ($urandom_range(0, 9))
                    0: begin
                        coef = 16'h8000;
                    end
                    1: begin
                        coef = 16'h7FFF;
                    end
                    2: begin
                        coef = 16'($urandom_range(0, 64) - 32);
                    end
                    default: begin
                        coef = 16'($urandom);
                    end
                endcase
                plan_quant(loaded_addrs[$urandom_range(0, loaded_addrs.size() - 1)], coef);
            end
        end
    endtask

    task automatic wait_idle();
        wait (n_checked >= n_planned);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_quality(input logic [6:0] q);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= q;
        do @(posedge i_clk); while (!cfg_if.ready);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // input driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            src_gap     <= 0;
        end else if (in_if.valid && !in_taken) begin
            in_if.valid <= 1'b1;
        end else if (src_gap > 0) begin
            in_if.valid <= 1'b0;
            src_gap     <= src_gap - 1;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            in_if.valid <= 1'b0;
            src_gap     <= $urandom_range(0, 12);
        end else if (send_queue.size() > 0) begin
            in_if.valid <= 1'b1;
            in_if.data  <= send_queue.pop_front();
        end else begin
            in_if.valid <= 1'b0;
        end
    end

    // result receiver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            out_if.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (!long_hold_done && n_checked > 250 && send_queue.size() > 30) begin
            // stall long enough to back up into the input
            out_if.ready   <= 1'b0;
            hold_left      <= HOLD_CYCLES;
            long_hold_done <= 1'b1;
        end else if (snk_gap > 0) begin
            out_if.ready <= 1'b0;
            snk_gap      <= snk_gap - 1;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            out_if.ready <= 1'b0;
            snk_gap      <= $urandom_range(0, 12);
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= in_if.valid && in_if.ready;
            if (cfg_if.valid && cfg_if.ready) quality_reg = cfg_if.data;
            if (in_if.valid && in_if.ready) quantizer_model(in_if.data);
            if (out_if.valid && out_if.ready) begin
                if (expected_results.size() == 0) begin
                    n_errors++;
                    $display("%0t: unexpected result, value %0d step_size %0d", $time,
                             out_if.data.value, out_if.data.step_size);
                end else begin
                    want = expected_results.pop_front();
                    if (out_if.data.value !== want.value) begin
                        n_errors++;
                        $display("%0t: value mismatch, expected %0d, actual %0d", $time,
                                 want.value, out_if.data.value);
                    end
                    if (out_if.data.step_size !== want.step_size) begin
                        n_errors++;
                        $display("%0t: step_size mismatch, expected %0d, actual %0d", $time,
                                 want.step_size, out_if.data.step_size);
                    end
                end
                n_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
                || (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        static int qual_plan [12] = '{50, 1, 49, 51, 99, -1, 2, 75, 100, -1, 25, -1};
        in_if.valid  = 1'b0;
        in_if.data   = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data  = '0;
        out_if.ready = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset quality: zero base, largest base, plain steps, coefficient extremes
        plan_load(1'b0, 6'd0, 8'd0);
        plan_load(1'b1, 6'd63, 8'd255);
        plan_load(1'b0, 6'd42, 8'd16);
        plan_load(1'b1, 6'd21, 8'd1);
        plan_quant({1'b0, 6'd0}, 16'h7FFF);
        plan_quant({1'b1, 6'd63}, 16'h8000);
        plan_quant({1'b0, 6'd42}, 16'h0000);
        plan_quant({1'b0, 6'd42}, 16'hFFFF);
        plan_quant({1'b1, 6'd21}, 16'h7FFF);
        plan_quant({1'b1, 6'd21}, 16'h8000);
        plan_quant({1'b0, 6'd42}, 16'h0001);
        wait_idle();

        // top quality: scale of zero
        set_quality(7'd100);
        plan_load(1'b0, 6'd5, 8'd200);
        plan_quant({1'b0, 6'd5}, 16'h8000);
        wait_idle();

        // zero acts as the lowest quality
        set_quality(7'd0);
        plan_load(1'b0, 6'd7, 8'd255);
        plan_quant({1'b0, 6'd7}, 16'h7FFF);
        plan_load(1'b1, 6'd9, 8'd1);
        plan_quant({1'b1, 6'd9}, 16'hCFC7);
        wait_idle();

        // above range acts as the top quality
        set_quality(7'd127);
        plan_load(1'b0, 6'd10, 8'd99);
        plan_quant({1'b0, 6'd10}, 16'hFFFF);
        wait_idle();

        foreach (qual_plan[p]) begin
            set_quality(qual_plan[p] < 0 ? 7'($urandom_range(0, 127)) : 7'(qual_plan[p]));
            if (p == 11) calm = 1'b1;
            plan_random(PHASE_ITEMS);
            wait_idle();
        end

        if (n_errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
